[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the terminal grid checkers
// Shared shorthand for clocked assertions on clock and reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is high.
`define TTG_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Assertion that is also checked across reset.
`define TTG_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[hw/rtl/ttg_pkg.sv]
// ---------------------------------------------------------------------------
// Terminal grid package
// Default geometry, operation codes, character codes and stream layouts.
// ---------------------------------------------------------------------------
package ttg_pkg;

   // Default geometry of the grid.
   localparam int COLUMNS_DEF = 64;
   localparam int ROWS_DEF    = 21;

   // Stream widths in bits; the tdata widths are padded to whole bytes.
   localparam int REQ_TDATA_W = 24;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 24;

   // Operation codes carried on req_tuser.
   localparam logic [1:0] OP_PUT   = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // Character codes.
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_BLANK = 8'h20;

   // Tab stops fall on multiples of this.
   localparam int TAB_STEP = 8;

   // Result beat layout, most significant member first.
   typedef struct packed {
      logic [2:0] pad;
      logic       scrolled;
      logic [7:0] cell_char;
      logic [4:0] cursor_row;
      logic [6:0] cursor_col;
   } result_type;

endpackage

[hw/rtl/ttg_ram.sv]
// ---------------------------------------------------------------------------
// Terminal grid RAM
// Generic single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ttg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1344
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/text_terminal_grid.sv]
// ---------------------------------------------------------------------------
// Text terminal character grid
// Character-cell terminal of ROWS lines by COLUMNS cells with a cursor.
// ---------------------------------------------------------------------------
// One request beat gives one response beat. The block works on one request
// at a time and drops req_tready from acceptance until its result has been
// moved into the output register. A control byte, a clear or a read of a
// blank row passes through S_EXEC and S_DONE, a printable byte also through
// S_WRITE and a stored-cell read also through S_RDWAIT. The grid lives in one
// RAM addressed through a rotating top-row pointer, so a scroll moves no cells;
// each row carries a valid bit, and the first printable byte written to a row
// after reset, a clear or a scroll first sweeps that row with blanks through
// the single RAM write port in S_SWEEP. There is no clearing pass after reset.
module text_terminal_grid #(
   parameter int COLUMNS = ttg_pkg::COLUMNS_DEF,
   parameter int ROWS    = ttg_pkg::ROWS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: char_code[7:0], read_row[12:8], read_col[18:13], zero pad
   input  logic [ttg_pkg::REQ_TDATA_W-1:0] req_tdata,
   // req_tuser: operation[1:0]
   input  logic [ttg_pkg::REQ_TUSER_W-1:0] req_tuser,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // rsp_tdata: cursor_col[6:0], cursor_row[11:7], cell_char[19:12],
   //            scrolled[20], zero pad
   output logic [ttg_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready
);

   import ttg_pkg::*;

   localparam int CW    = $clog2(COLUMNS + TAB_STEP + 1);
   localparam int RW    = $clog2(ROWS);
   localparam int XW    = $clog2(COLUMNS);
   localparam int DEPTH = ROWS * COLUMNS;
   localparam int AW    = $clog2(DEPTH);

   // Sequencer states.
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_WRITE  = 3'd2;
   localparam logic [2:0] S_SWEEP  = 3'd3;
   localparam logic [2:0] S_RDWAIT = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [1:0]        op_ff, op_in;
   logic [7:0]        char_ff, char_in;
   logic [4:0]        rrow_ff, rrow_in;
   logic [5:0]        rcol_ff, rcol_in;
   logic [CW-1:0]     col_ff, col_in;
   logic [RW-1:0]     row_ff, row_in;
   logic [RW-1:0]     top_ff, top_in;
   logic [ROWS-1:0]   valid_ff, valid_in;
   logic [XW-1:0]     wcol_ff, wcol_in;
   logic [XW-1:0]     cnt_ff, cnt_in;
   logic              scr_ff, scr_in;
   logic [7:0]        cell_ff, cell_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff, rsp_data_in;

   // Shared address unit and RAM port signals.
   logic [RW-1:0]     au_row;
   logic [XW-1:0]     au_col;
   logic [RW:0]       au_sum;
   logic [RW-1:0]     au_phys;
   logic [AW-1:0]     ram_addr;
   logic              ram_wr_en;
   logic              ram_rd_en;
   logic [7:0]        ram_wdata;
   logic [7:0]        ram_rdata;

   // Put and read decode helpers and the output-free flag.
   logic [CW-1:0]     tab_col;
   logic              printable;
   logic              wrap;
   logic              line_feed;
   logic              read_in_range;
   logic              out_free;

   // Logical row plus top pointer, folded into the grid, then the cell address.
   always_comb begin
      au_row = (op_ff == OP_READ) ? RW'(rrow_ff) : row_ff;
      if (state_ff == S_SWEEP) begin
         au_col = cnt_ff;
      end else if (op_ff == OP_READ) begin
         au_col = XW'(rcol_ff);
      end else begin
         au_col = wcol_ff;
      end
      au_sum = {1'b0, au_row} + {1'b0, top_ff};
      if (au_sum >= (RW + 1)'(ROWS)) begin
         au_phys = RW'(au_sum - (RW + 1)'(ROWS));
      end else begin
         au_phys = RW'(au_sum);
      end
      ram_addr = AW'(32'(au_phys) * 32'(COLUMNS) + 32'(au_col));
   end

   assign tab_col       = (col_ff + CW'(TAB_STEP)) & ~CW'(TAB_STEP - 1);
   assign printable     = (char_ff >= CH_BLANK) && !char_ff[7];
   assign wrap          = col_ff >= CW'(COLUMNS);
   assign read_in_range = (32'(rrow_ff) < 32'(ROWS)) && (32'(rcol_ff) < 32'(COLUMNS));
   assign out_free      = !rsp_valid_ff || rsp_tready;

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      char_in      = char_ff;
      rrow_in      = rrow_ff;
      rcol_in      = rcol_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      top_in       = top_ff;
      valid_in     = valid_ff;
      wcol_in      = wcol_ff;
      cnt_in       = cnt_ff;
      scr_in       = scr_ff;
      cell_in      = cell_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      ram_wdata    = CH_BLANK;
      line_feed    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser[1:0];
               char_in  = req_tdata[7:0];
               rrow_in  = req_tdata[12:8];
               rcol_in  = req_tdata[18:13];
               scr_in   = 1'b0;
               cell_in  = '0;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            state_in = S_DONE;
            unique case (op_ff)
               OP_PUT: begin
                  unique case (char_ff)
                     CH_LF: begin
                        col_in    = '0;
                        line_feed = 1'b1;
                     end
                     CH_CR: begin
                        col_in = '0;
                     end
                     CH_BS: begin
                        if (col_ff != '0) begin
                           col_in = col_ff - 1'b1;
                        end
                     end
                     CH_TAB: begin
                        if (tab_col >= CW'(COLUMNS)) begin
                           col_in    = '0;
                           line_feed = 1'b1;
                        end else begin
                           col_in = tab_col;
                        end
                     end
                     default: begin
                        // Printable bytes wrap first when the row is full.
                        if (printable) begin
                           line_feed = wrap;
                           wcol_in   = wrap ? '0 : XW'(col_ff);
                           col_in    = wrap ? CW'(1) : col_ff + 1'b1;
                           state_in  = S_WRITE;
                        end
                     end
                  endcase

                  // Moving down from the bottom row rotates the top pointer and
                  // retires the old top row, which becomes the blank bottom row.
                  if (line_feed) begin
                     if (row_ff == RW'(ROWS - 1)) begin
                        top_in           = (top_ff == RW'(ROWS - 1)) ? '0 : top_ff + 1'b1;
                        valid_in[top_ff] = 1'b0;
                        scr_in           = 1'b1;
                     end else begin
                        row_in = row_ff + 1'b1;
                     end
                  end
               end

               OP_READ: begin
                  if (read_in_range) begin
                     if (valid_ff[au_phys]) begin
                        ram_rd_en = 1'b1;
                        state_in  = S_RDWAIT;
                     end else begin
                        cell_in = CH_BLANK;
                     end
                  end
               end

               OP_CLEAR: begin
                  valid_in = '0;
                  top_in   = '0;
                  row_in   = '0;
                  col_in   = '0;
               end

               default: begin
               end
            endcase
         end

         S_WRITE: begin
            if (valid_ff[au_phys]) begin
               ram_wr_en = 1'b1;
               ram_wdata = char_ff;
               state_in  = S_DONE;
            end else begin
               cnt_in   = '0;
               state_in = S_SWEEP;
            end
         end

         // Blank a fresh row one cell a cycle, dropping the byte in on the way.
         S_SWEEP: begin
            ram_wr_en = 1'b1;
            ram_wdata = (cnt_ff == wcol_ff) ? char_ff : CH_BLANK;
            if (cnt_ff == XW'(COLUMNS - 1)) begin
               valid_in[au_phys] = 1'b1;
               state_in          = S_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         S_RDWAIT: begin
            cell_in  = ram_rdata;
            state_in = S_DONE;
         end

         S_DONE: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.pad        = '0;
               rsp_data_in.scrolled   = scr_ff;
               rsp_data_in.cell_char  = cell_ff;
               rsp_data_in.cursor_row = 5'(32'(row_ff));
               rsp_data_in.cursor_col = 7'(32'(col_ff));
               state_in               = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control and cursor state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         top_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         top_ff       <= top_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      char_ff     <= char_in;
      rrow_ff     <= rrow_in;
      rcol_ff     <= rcol_in;
      wcol_ff     <= wcol_in;
      cnt_ff      <= cnt_in;
      scr_ff      <= scr_in;
      cell_ff     <= cell_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Character store.
   ttg_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_ttg_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_addr),
      .wr_data (ram_wdata),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_addr),
      .rd_data (ram_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[hw/rtl/ttg_checker.sv]
// ---------------------------------------------------------------------------
// Terminal grid checker
// Port-level assertions on the terminal grid, attached by a bind.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ttg_checker #(
   parameter int ROWS = ttg_pkg::ROWS_DEF
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   // rsp_tdata: cursor_col[6:0], cursor_row[11:7], cell_char[19:12],
   //            scrolled[20], zero pad
   input logic [ttg_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready
);

   import ttg_pkg::*;

   // A stalled response beat keeps its value.
   `TTG_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "response beat changed while stalled")

   // Reset empties the output register.
   `TTG_ASSERT_RST(a_rsp_reset, reset |=> !rsp_tvalid, "response valid after reset")

   // One request at a time: the block is busy in the cycle after a beat.
   `TTG_ASSERT(a_busy, req_tvalid && req_tready |=> !req_tready, "request taken while busy")

   // A scroll leaves the cursor on the bottom row.
   `TTG_ASSERT(a_scroll_row, rsp_tvalid && rsp_tdata[20] |-> rsp_tdata[11:7] == 5'(ROWS - 1), "scroll left cursor off the bottom row")

   // A scroll leaves the cursor in the first or second column.
   `TTG_ASSERT(a_scroll_col, rsp_tvalid && rsp_tdata[20] |-> rsp_tdata[6:0] == 7'd0 || rsp_tdata[6:0] == 7'd1, "scroll left cursor beyond column one")

endmodule

bind text_terminal_grid ttg_checker #(.ROWS(ROWS)) u_ttg_checker (.*);

[dv/testbench.sv]
// ---------------------------------------------------------------------------
// Testbench for the text terminal character grid
// Drives request beats of put, read, clear and unused operations into the
// grid, keeps its own copy of the cells and the cursor, and checks every
// result beat field by field. Both sides idle at random but in the back-to-back test.
// ---------------------------------------------------------------------------
module testbench;

   import ttg_pkg::*;

   localparam int COLUMNS = COLUMNS_DEF;
   localparam int ROWS    = ROWS_DEF;

   // Operation code with no defined action.
   localparam logic [1:0] OP_NOP = 2'd3;

   // Cycles without any beat before the run is abandoned.
   localparam int QUIET_LIMIT = 4000;

   logic                   clock;
   logic                   reset;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [REQ_TUSER_W-1:0] req_tuser;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;

   // Own copy of the grid and the cursor.
   logic [7:0] grid_cells [ROWS][COLUMNS];
   int         cursor_x;
   int         cursor_y;

   // Results still to arrive, oldest first.
   result_type expected_reports [$];

   int req_beats;
   int rsp_beats;
   int mismatch_count;
   int quiet_cycles;
   int idle_max;
   int read_total;
   int scroll_total;
   int wrap_total;

   text_terminal_grid #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready)
   );

   // Clock with a period of 20 time units.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Fill the whole grid with blanks and home the cursor.
   function automatic void blank_grid();
      for (int r = 0; r < ROWS; r++) begin
         for (int c = 0; c < COLUMNS; c++) begin
            grid_cells[r][c] = CH_BLANK;
         end
      end
      cursor_x = 0;
      cursor_y = 0;
   endfunction

   // Move the cursor down a row; at the bottom the grid rolls up by one row.
   function automatic bit next_line();
      cursor_y++;
      if (cursor_y < ROWS) begin
         return 1'b0;
      end
      for (int r = 0; r < ROWS - 1; r++) begin
         for (int c = 0; c < COLUMNS; c++) begin
            grid_cells[r][c] = grid_cells[r + 1][c];
         end
      end
      for (int c = 0; c < COLUMNS; c++) begin
         grid_cells[ROWS - 1][c] = CH_BLANK;
      end
      cursor_y = ROWS - 1;
      scroll_total++;
      return 1'b1;
   endfunction

   // Apply one byte to the grid; returns whether the grid rolled up.
   function automatic bit apply_byte(logic [7:0] code);
      bit rolled;
      rolled = 1'b0;
      case (code)
         CH_LF: begin
            cursor_x = 0;
            rolled = next_line();
         end
         CH_CR: begin
            cursor_x = 0;
         end
         CH_BS: begin
            if (cursor_x > 0) cursor_x--;
         end
         CH_TAB: begin
            cursor_x = (cursor_x + TAB_STEP) & ~(TAB_STEP - 1);
            if (cursor_x >= COLUMNS) begin
               cursor_x = 0;
               wrap_total++;
               rolled = next_line();
            end
         end
         default: begin
            // Only 0x20 to 0x7F are stored; the rest is ignored.
            if (code >= CH_BLANK && !code[7]) begin
               if (cursor_x >= COLUMNS) begin
                  cursor_x = 0;
                  wrap_total++;
                  rolled = next_line();
               end
               grid_cells[cursor_y][cursor_x] = code;
               cursor_x++;
            end
         end
      endcase
      return rolled;
   endfunction

   // Work out the result beat of one accepted request and update the grid.
   function automatic result_type predict_grid_step(logic [1:0] op, logic [7:0] code,
                                                    logic [4:0] row, logic [5:0] col);
      result_type res;
      res = '0;
      case (op)
         OP_PUT: begin
            res.scrolled = apply_byte(code);
         end
         OP_READ: begin
            read_total++;
            if (row < ROWS && col < COLUMNS) res.cell_char = grid_cells[row][col];
         end
         OP_CLEAR: begin
            blank_grid();
         end
         default: begin
         end
      endcase
      res.cursor_col = cursor_x[6:0];
      res.cursor_row = cursor_y[4:0];
      return res;
   endfunction

   // Compare one field and report the first few differences.
   function automatic void check_field(string field, int want, int got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("tb: result %0d, %s differs: expected %0d, got %0d",
                     rsp_beats, field, want, got);
         end
      end
   endfunction

   // Check result beats and predict accepted request beats at each rising edge.
   always @(posedge clock) begin : scoreboard
      result_type got;
      result_type want;
      if (reset) begin
         blank_grid();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_beats++;
            got = rsp_tdata;
            if (expected_reports.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("tb: result %0d arrived with none outstanding", rsp_beats);
               end
            end else begin
               want = expected_reports.pop_front();
               check_field("cursor_col", want.cursor_col, got.cursor_col);
               check_field("cursor_row", want.cursor_row, got.cursor_row);
               check_field("cell_char", want.cell_char, got.cell_char);
               check_field("scrolled", want.scrolled, got.scrolled);
               check_field("padding", want.pad, got.pad);
            end
         end
         if (req_tvalid && req_tready) begin
            req_beats++;
            expected_reports.push_back(predict_grid_step(req_tuser, req_tdata[7:0],
                                                         req_tdata[12:8], req_tdata[18:13]));
         end
      end
   end

   // Abandon the run when no beat moves for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: no beat moved for %0d cycles", QUIET_LIMIT);
            $display("tb: failure");
            $finish;
         end
      end
   end

   // Result side: stall a random number of cycles before taking each beat.
   initial begin : result_sink
      int stall;
      int seen;
      rsp_tready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = (idle_max == 0) ? 0 : $urandom_range(idle_max, 0);
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         seen = rsp_beats;
         while (rsp_beats == seen) @(negedge clock);
      end
   end

   // Send one request beat after a random gap and wait until it is taken.
   task automatic send_item(input logic [1:0] op, input logic [7:0] code,
                            input logic [4:0] row, input logic [5:0] col);
      int gap;
      int seen;
      gap = (idle_max == 0) ? 0 : $urandom_range(idle_max, 0);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  = op;
      req_tdata  = {5'd0, col, row, code};
      req_tvalid = 1'b1;
      seen = req_beats;
      while (req_beats == seen) @(negedge clock);
   endtask

   // One beat of a text stream; line_breaks is the share of LF or CR bytes in percent.
   task automatic send_text_item(input int line_breaks);
      int pick;
      logic [4:0] row;
      if ($urandom_range(299) == 0) begin
         send_item(OP_CLEAR, 8'($urandom), 5'($urandom), 6'($urandom));
      end else if ($urandom_range(99) < line_breaks) begin
         send_item(OP_PUT, ($urandom_range(3) == 0) ? CH_CR : CH_LF,
                   5'($urandom), 6'($urandom));
      end else begin
         pick = $urandom_range(99);
         if (pick < 75) begin
            send_item(OP_PUT, 8'($urandom_range(127, 32)), 5'($urandom), 6'($urandom));
         end else if (pick < 80) begin
            send_item(OP_PUT, CH_TAB, 5'($urandom), 6'($urandom));
         end else if (pick < 85) begin
            send_item(OP_PUT, CH_BS, 5'($urandom), 6'($urandom));
         end else if (pick < 95) begin
            // Half the reads look at the cursor row, where the text is.
            case ($urandom_range(3))
               0, 1: row = 5'(cursor_y);
               2: row = 5'($urandom_range(ROWS - 1));
               default: row = 5'($urandom);
            endcase
            send_item(OP_READ, 8'($urandom), row, 6'($urandom));
         end else if (pick < 97) begin
            send_item(OP_PUT, 8'($urandom_range(255, 128)), 5'($urandom), 6'($urandom));
         end else begin
            send_item(OP_PUT, 8'($urandom_range(31)), 5'($urandom), 6'($urandom));
         end
      end
   endtask

   // Extremes of each field, every operation and the special bytes.
   task automatic test_directed();
      send_item(OP_READ, 8'h00, 5'd0, 6'd0);
      send_item(OP_PUT, 8'h41, 5'd0, 6'd0);
      send_item(OP_PUT, 8'h7F, 5'd31, 6'd63);
      send_item(OP_PUT, CH_BLANK, 5'd0, 6'd0);
      send_item(OP_READ, 8'hFF, 5'd0, 6'd0);
      send_item(OP_READ, 8'h00, 5'd0, 6'd1);
      send_item(OP_PUT, 8'h80, 5'd0, 6'd0);
      send_item(OP_PUT, 8'hFF, 5'd0, 6'd0);
      send_item(OP_PUT, 8'h00, 5'd0, 6'd0);
      send_item(OP_PUT, 8'h1F, 5'd0, 6'd0);
      send_item(OP_PUT, CH_BS, 5'd0, 6'd0);
      send_item(OP_PUT, CH_CR, 5'd0, 6'd0);
      send_item(OP_PUT, CH_BS, 5'd0, 6'd0);
      send_item(OP_PUT, CH_TAB, 5'd0, 6'd0);
      send_item(OP_PUT, CH_TAB, 5'd0, 6'd0);
      send_item(OP_PUT, CH_LF, 5'd0, 6'd0);
      send_item(OP_READ, 8'h00, 5'(ROWS - 1), 6'(COLUMNS - 1));
      // Rows past the bottom read as zero.
      send_item(OP_READ, 8'h00, 5'd31, 6'd63);
      send_item(OP_READ, 8'h00, 5'(ROWS), 6'd0);
      send_item(OP_NOP, 8'hFF, 5'd31, 6'd63);
      send_item(OP_CLEAR, 8'h00, 5'd0, 6'd0);
      send_item(OP_READ, 8'h00, 5'd0, 6'd0);
   endtask

   // Text in phases of many, some and hardly any line breaks, so that the
   // cursor both scrolls the grid and runs into the right-hand edge.
   task automatic test_text_stream();
      int breaks [3] = '{40, 12, 2};
      for (int phase = 0; phase < 8; phase++) begin
         repeat (90) send_text_item(breaks[phase % 3]);
      end
   endtask

   // Fully random beats, the unused operation included.
   task automatic test_random_noise();
      repeat (150) begin
         send_item(2'($urandom), 8'($urandom), 5'($urandom), 6'($urandom));
      end
   endtask

   // Text with neither side idling.
   task automatic test_back_to_back();
      idle_max = 0;
      repeat (100) send_text_item(12);
      idle_max = 8;
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      idle_max   = 8;
      req_beats      = 0;
      rsp_beats      = 0;
      mismatch_count = 0;
      quiet_cycles   = 0;
      read_total     = 0;
      scroll_total   = 0;
      wrap_total     = 0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_text_stream();
      test_random_noise();
      test_back_to_back();
      req_tvalid = 1'b0;

      // Drain the outstanding results, then allow for a late extra beat.
      while (expected_reports.size() != 0) @(negedge clock);
      repeat (2 * COLUMNS + 16) @(negedge clock);

      $display("tb: %0d request beats and %0d result beats, %0d of them reads",
               req_beats, rsp_beats, read_total);
      $display("tb: %0d scrolls and %0d line wraps, %0d differences",
               scroll_total, wrap_total, mismatch_count);
      if (mismatch_count == 0 && expected_reports.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/ttg_pkg.sv
hw/rtl/ttg_ram.sv
hw/rtl/text_terminal_grid.sv
hw/rtl/ttg_checker.sv
dv/testbench.sv
